// ===== src/tmf_pkg.sv =====
package tmf_pkg;

  localparam int unsigned CHANNELS      = 32;
  localparam int unsigned HISTORY_DEPTH = 4;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MED_W    = 17;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned CHAN_O_W = 5;
  localparam int unsigned USED_O_W = 3;

  localparam int unsigned NVALS  = HISTORY_DEPTH + 1;
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(NVALS + 1);
  localparam int unsigned IDX_W  = $clog2(NVALS);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t hist_row_t [HISTORY_DEPTH];

  typedef struct packed {
    sample_t           sample;
    logic [CH_W-1:0]   chan;
    logic [FILL_W-1:0] fill;
    logic              frame_end;
  } stage_t;

endpackage

// ===== src/tmf_hist.sv =====
module tmf_hist (
  input  logic                       clk_i,
  input  logic                       req_i,
  input  logic [tmf_pkg::CH_W-1:0]   addr_i,
  input  logic [tmf_pkg::SLOT_W-1:0] slot_i,
  input  tmf_pkg::sample_t           wdata_i,
  output tmf_pkg::hist_row_t         rdata_o
);

  tmf_pkg::sample_t mem_q [tmf_pkg::HISTORY_DEPTH][tmf_pkg::CHANNELS];
  tmf_pkg::sample_t rd_q  [tmf_pkg::HISTORY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      for (int k = 0; k < tmf_pkg::HISTORY_DEPTH; k++) begin
        rd_q[k] <= mem_q[k][addr_i];
      end
      mem_q[slot_i][addr_i] <= wdata_i;
    end
  end

  always_comb begin
    for (int k = 0; k < tmf_pkg::HISTORY_DEPTH; k++) begin
      rdata_o[k] = rd_q[k];
    end
  end

endmodule

// ===== src/tmf_median.sv =====
module tmf_median (
  input  tmf_pkg::hist_row_t                 hist_i,
  input  tmf_pkg::stage_t                    stage_i,
  output logic signed [tmf_pkg::MED_W-1:0]   med_o,
  output logic [tmf_pkg::CNT_W-1:0]          count_o
);

  localparam logic signed [tmf_pkg::MED_W-1:0] SENTINEL = tmf_pkg::MED_W'(32768);

  logic signed [tmf_pkg::MED_W-1:0] v [tmf_pkg::NVALS];
  logic [tmf_pkg::CNT_W-1:0]        n;
  logic [tmf_pkg::IDX_W-1:0]        lo_idx;
  logic [tmf_pkg::IDX_W-1:0]        hi_idx;
  logic signed [tmf_pkg::MED_W:0]   sum;

  always_comb begin
    logic signed [tmf_pkg::MED_W-1:0] tmp;
    tmp = '0;
    for (int k = 0; k < tmf_pkg::HISTORY_DEPTH; k++) begin
      v[k] = (k < stage_i.fill) ? tmf_pkg::MED_W'(hist_i[k]) : SENTINEL;
    end
    v[tmf_pkg::HISTORY_DEPTH] = tmf_pkg::MED_W'(stage_i.sample);
    // odd-even transposition network, unused slots sink to the top
    for (int p = 0; p < tmf_pkg::NVALS; p++) begin
      for (int k = 0; k < tmf_pkg::NVALS - 1; k++) begin
        if ((k % 2) == (p % 2)) begin
          if (v[k] > v[k+1]) begin
            tmp    = v[k];
            v[k]   = v[k+1];
            v[k+1] = tmp;
          end
        end
      end
    end
  end

  assign n      = tmf_pkg::CNT_W'(stage_i.fill) + tmf_pkg::CNT_W'(1);
  assign lo_idx = tmf_pkg::IDX_W'((n - tmf_pkg::CNT_W'(1)) >> 1);
  assign hi_idx = tmf_pkg::IDX_W'(n >> 1);
  assign sum    = (tmf_pkg::MED_W+1)'(v[lo_idx]) + (tmf_pkg::MED_W+1)'(v[hi_idx]);
  assign med_o  = sum[tmf_pkg::MED_W-1:0];
  assign count_o = n;

endmodule

// ===== src/temporal_median_filter_unit.sv =====
// Channel   Ports                              Moves
// in        in_valid_i / in_ready_o            sample_i
// out       out_valid_o / out_ready_i          median_doubled_o, channel_o,
//                                              values_used_o, frame_end_o
// cfg       cfg_we_i                           cfg_wdata_i (channels in use)
//
// One request per cycle sustained while the output is not stalled; each
// request passes the history read register, then the result register.
// The history row is read and the new sample written in the same cycle.
// Reset clears channel counter, ring slot, fill count and valids; history
// itself is not cleared. A stalled output holds the stage behind it.
module temporal_median_filter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tmf_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [tmf_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tmf_pkg::MED_W-1:0]     median_doubled_o,
  output logic [tmf_pkg::CHAN_O_W-1:0]         channel_o,
  output logic [tmf_pkg::USED_O_W-1:0]         values_used_o,
  output logic                                 frame_end_o
);

  logic [tmf_pkg::CFG_W-1:0]  cfg_q;
  logic [tmf_pkg::CH_W-1:0]   ch_q, ch_d;
  logic [tmf_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [tmf_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                       s1_valid_q;
  tmf_pkg::stage_t            s1_q;
  logic                       out_valid_q;
  logic signed [tmf_pkg::MED_W-1:0] med_q;
  logic [tmf_pkg::CH_W-1:0]   chan_q;
  logic [tmf_pkg::CNT_W-1:0]  used_q;
  logic                       end_q;

  logic [tmf_pkg::CH_W-1:0]   last_ch;
  logic                       in_fire;
  logic                       out_free;
  logic                       at_end;
  tmf_pkg::hist_row_t         hist_row;
  logic signed [tmf_pkg::MED_W-1:0] med;
  logic [tmf_pkg::CNT_W-1:0]  count;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_q == '0) begin
      last_ch = '0;
    end else if (cfg_q > tmf_pkg::CHANNELS) begin
      last_ch = tmf_pkg::CH_W'(tmf_pkg::CHANNELS - 1);
    end else begin
      last_ch = tmf_pkg::CH_W'(cfg_q - tmf_pkg::CFG_W'(1));
    end
  end

  assign at_end = (ch_q >= last_ch);

  always_comb begin
    ch_d   = ch_q;
    slot_d = slot_q;
    fill_d = fill_q;
    if (in_fire) begin
      if (at_end) begin
        ch_d = '0;
        if (slot_q == tmf_pkg::SLOT_W'(tmf_pkg::HISTORY_DEPTH - 1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + tmf_pkg::SLOT_W'(1);
        end
        if (fill_q != tmf_pkg::FILL_W'(tmf_pkg::HISTORY_DEPTH)) begin
          fill_d = fill_q + tmf_pkg::FILL_W'(1);
        end
      end else begin
        ch_d = ch_q + tmf_pkg::CH_W'(1);
      end
    end
  end

  tmf_hist u_hist (
    .clk_i   (clk_i),
    .req_i   (in_fire),
    .addr_i  (ch_q),
    .slot_i  (slot_q),
    .wdata_i (sample_i),
    .rdata_o (hist_row)
  );

  tmf_median u_median (
    .hist_i  (hist_row),
    .stage_i (s1_q),
    .med_o   (med),
    .count_o (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= tmf_pkg::CFG_RESET;
      ch_q        <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      ch_q   <= ch_d;
      slot_q <= slot_d;
      fill_q <= fill_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.sample    <= sample_i;
      s1_q.chan      <= ch_q;
      s1_q.fill      <= fill_q;
      s1_q.frame_end <= at_end;
    end
    if (out_free && s1_valid_q) begin
      med_q  <= med;
      chan_q <= s1_q.chan;
      used_q <= count;
      end_q  <= s1_q.frame_end;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign channel_o        = tmf_pkg::CHAN_O_W'(chan_q);
  assign values_used_o    = tmf_pkg::USED_O_W'(used_q);
  assign frame_end_o      = end_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= tmf_pkg::FILL_W'(tmf_pkg::HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (used_q != '0) && (used_q <= tmf_pkg::CNT_W'(tmf_pkg::NVALS)))
    else $error("values used out of range");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && at_end |=> ch_q == '0)
    else $error("channel counter not cleared at frame end");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_q))
    else $error("stalled stage lost its request");
`endif

endmodule
